// File: design/pct_pkg.sv
// Shared widths, register codes and helpers for the partitioned clock-to-time block.
package pct_pkg;

  localparam int TICK_W    = 48;
  localparam int TIME_W    = 48;
  localparam int RATE_W    = 32;
  localparam int COUNT_W   = 6;
  localparam int IDX_W     = 5;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_PARTITIONS_DEF = 32;

  // multiplier slice: the tick difference is split into two halves of this width
  localparam int MUL_A_W  = 24;
  localparam int MUL_P_W  = MUL_A_W + RATE_W;
  localparam int ACC_W    = TICK_W + RATE_W;
  localparam int FRAC_W   = 30;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);
  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(32'h4000_0000);

  // round to nearest, ties toward +infinity, on the signed product
  localparam logic [ACC_W-1:0] ROUND_POS = ACC_W'(1) << (FRAC_W - 1);
  localparam logic [ACC_W-1:0] ROUND_NEG = (ACC_W'(1) << (FRAC_W - 1)) - ACC_W'(1);

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_CONVERT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PART_COUNT = 2'd0,
    REG_START      = 2'd1,
    REG_BASE       = 2'd2,
    REG_RATE       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [TICK_W-1:0] start;
    logic [TICK_W-1:0] stop;
  } part_entry_t;

endpackage

// File: design/pct_if.sv
// Valid/ready channel interfaces for request and result items.
interface pct_in_if
  import pct_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              action;
  logic [IDX_W-1:0]  entry_index;
  logic [TICK_W-1:0] part_start;
  logic [TICK_W-1:0] part_stop;
  logic [TICK_W-1:0] raw_ticks;

  modport source (output valid, action, entry_index, part_start, part_stop, raw_ticks,
                  input ready);
  modport sink   (input valid, action, entry_index, part_start, part_stop, raw_ticks,
                  output ready);
endinterface

interface pct_out_if
  import pct_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] corrected_ticks;
  logic [TIME_W-1:0] time_out;
  logic              partition_found;
  logic [IDX_W-1:0]  partition_index;

  modport source (output valid, corrected_ticks, time_out, partition_found,
                  partition_index, input ready);
  modport sink   (input valid, corrected_ticks, time_out, partition_found,
                  partition_index, output ready);
endinterface

// File: design/pct_table.sv
// Partition start/stop table: one write port, one registered read port.
module pct_table
  import pct_pkg::*;
#(
  parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF,
  parameter int AW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  part_entry_t   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output part_entry_t   rdata
);

  part_entry_t mem [MAX_PARTITIONS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/pct_mul.sv
// Shared 24 x 32 unsigned multiplier with registered product.
module pct_mul
  import pct_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [RATE_W-1:0]  b,
  output logic [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

// File: design/partitioned_clock_to_time_core.sv
// Top level: partition walk sequencer, time scaling and channel handshakes.
//
//  port     | dir | carries
//  ---------+-----+----------------------------------------------------------
//  item     | in  | load of one partition entry, or raw ticks to convert
//  result   | out | corrected ticks, time, found flag, partition index
//  cfg_*    | in  | register writes: count, start ticks, base time, rate
//
// A load writes its table entry when accepted. A convert holds the input off
// until its result is handed off: the walk reads n table entries through the
// single read port (n = partition count, capped at MAX_PARTITIONS) and drains
// the last read, then clamp, difference, two multiplier passes, accumulate, time
// add and hand-off. The next request can be taken in the cycle after that.
// Reset is synchronous; table contents are not cleared.
// The block takes a new request while a finished result waits; a convert
// holds in its last state until the result register frees up.
module partitioned_clock_to_time_core
  import pct_pkg::*;
#(
  parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  pct_in_if.sink               item,
  pct_out_if.source            result
);

  localparam int AW    = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
  localparam int CW    = TICK_W + 3 + CNT_W;
  localparam int RES_W = ACC_W - FRAC_W;
  localparam int T_W   = RES_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_CLAMP, S_DIFF, S_MUL_LO, S_MUL_HI, S_ACC, S_TIME, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [COUNT_W-1:0] part_count;
  logic [TICK_W-1:0]  epoch_ticks;
  logic [TIME_W-1:0]  base_time;
  logic [RATE_W-1:0]  tick_rate;

  // walk
  logic [TICK_W-1:0]  ticks;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   pend_k;
  logic               pend;
  logic signed [CW-1:0] sum;
  logic signed [CW-1:0] corr_c;
  logic               found;
  logic [IDX_W-1:0]   idx;

  // scaling
  logic [TICK_W-1:0]  corr;
  logic               neg;
  logic [TICK_W-1:0]  mag;
  logic [ACC_W-1:0]   acc;
  logic [TIME_W-1:0]  time_val;

  // output register
  logic               out_valid;
  logic [TICK_W-1:0]  out_corr;
  logic [TIME_W-1:0]  out_time;
  logic               out_found;
  logic [IDX_W-1:0]   out_idx;

  // table
  logic               tbl_we;
  logic [AW-1:0]      tbl_waddr;
  part_entry_t        tbl_wdata;
  logic               tbl_re;
  part_entry_t        tbl_rdata;

  // multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_P_W-1:0] mul_p;

  logic               accept;
  logic               match;
  logic signed [CW-1:0] ticks_s;
  logic signed [CW-1:0] start_s;
  logic signed [CW-1:0] stop_s;
  logic signed [CW-1:0] cand;
  logic [TICK_W:0]    diff;
  logic [RES_W-1:0]   res;
  logic signed [T_W-1:0] q;
  logic signed [T_W-1:0] t;
  logic [CNT_W-1:0]   n_sat;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;

  assign tbl_we    = accept && (item.action == ACT_LOAD) &&
                     ({27'd0, item.entry_index} < 32'(MAX_PARTITIONS));
  assign tbl_waddr = AW'(item.entry_index);
  assign tbl_wdata = '{start: item.part_start, stop: item.part_stop};
  assign tbl_re    = (state == S_WALK) && (k < n);

  pct_table #(.MAX_PARTITIONS(MAX_PARTITIONS), .AW(AW)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (k[AW-1:0]),
    .rdata (tbl_rdata)
  );

  assign mul_a = (state == S_MUL_HI) ? mag[TICK_W-1:MUL_A_W] : mag[MUL_A_W-1:0];

  pct_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (tick_rate),
    .p   (mul_p)
  );

  always_comb begin
    ticks_s = $signed({{(CW-TICK_W){1'b0}}, ticks});
    start_s = $signed({{(CW-TICK_W){1'b0}}, tbl_rdata.start});
    stop_s  = $signed({{(CW-TICK_W){1'b0}}, tbl_rdata.stop});
    match   = (ticks >= tbl_rdata.start) && (ticks <= tbl_rdata.stop);
    cand    = sum + ticks_s - start_s;

    n_sat = (32'(part_count) > 32'(MAX_PARTITIONS)) ? CNT_W'(MAX_PARTITIONS)
                                                    : CNT_W'(part_count);

    diff = {1'b0, corr} - {1'b0, epoch_ticks};

    res = acc[ACC_W-1:FRAC_W];
    q   = neg ? -$signed({2'b00, res}) : $signed({2'b00, res});
    t   = $signed({{(T_W-TIME_W){base_time[TIME_W-1]}}, base_time}) + q;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      part_count  <= COUNT_RESET;
      epoch_ticks <= '0;
      base_time   <= '0;
      tick_rate   <= RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PART_COUNT: part_count  <= cfg_data[COUNT_W-1:0];
        REG_START:      epoch_ticks <= cfg_data[TICK_W-1:0];
        REG_BASE:       base_time   <= cfg_data[TIME_W-1:0];
        REG_RATE:       tick_rate   <= cfg_data[RATE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      // S_DONE loads the result register itself
      if (out_valid && result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && (item.action == ACT_CONVERT)) begin
            ticks  <= item.raw_ticks;
            n      <= n_sat;
            k      <= '0;
            pend   <= 1'b0;
            sum    <= '0;
            found  <= 1'b0;
            idx    <= '0;
            corr_c <= $signed({{(CW-TICK_W){1'b0}}, item.raw_ticks});
            state  <= S_WALK;
          end
        end

        S_WALK: begin
          // read of entry k issued this cycle; entry pend_k is on rdata
          if (k < n) begin
            k      <= k + CNT_W'(1);
            pend   <= 1'b1;
            pend_k <= k;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (match) begin
              found  <= 1'b1;
              idx    <= IDX_W'(pend_k);
              corr_c <= (pend_k == '0) ? ticks_s : cand;
            end
            sum <= sum + stop_s - start_s;
          end
          if (!(k < n) && !pend) begin
            state <= S_CLAMP;
          end
        end

        S_CLAMP: begin
          if (corr_c < 0) begin
            corr <= '0;
          end else if (|corr_c[CW-1:TICK_W]) begin
            corr <= '1;
          end else begin
            corr <= corr_c[TICK_W-1:0];
          end
          state <= S_DIFF;
        end

        S_DIFF: begin
          neg   <= diff[TICK_W];
          mag   <= diff[TICK_W] ? TICK_W'(-diff) : diff[TICK_W-1:0];
          state <= S_MUL_LO;
        end

        S_MUL_LO: begin
          state <= S_MUL_HI;
        end

        S_MUL_HI: begin
          // low partial product is ready
          acc   <= ACC_W'(mul_p) + (neg ? ROUND_NEG : ROUND_POS);
          state <= S_ACC;
        end

        S_ACC: begin
          acc   <= acc + (ACC_W'(mul_p) << MUL_A_W);
          state <= S_TIME;
        end

        S_TIME: begin
          if (t[T_W-1:TIME_W-1] == '0 || t[T_W-1:TIME_W-1] == '1) begin
            time_val <= t[TIME_W-1:0];
          end else if (t[T_W-1]) begin
            time_val <= {1'b1, {(TIME_W-1){1'b0}}};
          end else begin
            time_val <= {1'b0, {(TIME_W-1){1'b1}}};
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_corr  <= corr;
            out_time  <= time_val;
            out_found <= found;
            out_idx   <= idx;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid           = out_valid;
  assign result.corrected_ticks = out_corr;
  assign result.time_out        = out_time;
  assign result.partition_found = out_found;
  assign result.partition_index = out_idx;

endmodule
